// ===== src/pesp_pkg.sv =====
// Package for the PES packet header parser: phase codes, result and error codes, config indices and step outcomes.
// No dependencies.
`default_nettype none
package pesp_pkg;
  typedef enum logic [14:0] {
    PH_PREFIX   = 15'h0001,
    PH_HUNT     = 15'h0002,
    PH_ID       = 15'h0004,
    PH_LEN_HI   = 15'h0008,
    PH_LEN_LO   = 15'h0010,
    PH_M1_STUFF = 15'h0020,
    PH_M1_STD2  = 15'h0040,
    PH_M1_LEAD  = 15'h0080,
    PH_M2_B0    = 15'h0100,
    PH_M2_B1    = 15'h0200,
    PH_M2_B2    = 15'h0400,
    PH_TS       = 15'h0800,
    PH_M2_SKIP  = 15'h1000,
    PH_PAYLOAD  = 15'h2000,
    PH_SKIP     = 15'h4000
  } phase_t;

  localparam logic [1:0] KIND_HEADER  = 2'd0;
  localparam logic [1:0] KIND_PAYLOAD = 2'd1;
  localparam logic [1:0] KIND_ERROR   = 2'd2;

  localparam logic [1:0] ERR_PREFIX = 2'd0;
  localparam logic [1:0] ERR_MARKER = 2'd1;
  localparam logic [1:0] ERR_SHORT  = 2'd2;

  localparam logic [0:0] CFG_WANTED_ID = 1'b0;
  localparam logic [0:0] CFG_MPEG2     = 1'b1;

  typedef enum logic [1:0] {
    GO_ON    = 2'd0,
    GO_BAD   = 2'd1,
    GO_DONE  = 2'd2,
    GO_SHORT = 2'd3
  } go_t;
endpackage
`default_nettype wire

// ===== src/pes_packet_header_parser_top.sv =====
// PES packet header parser top level: byte parser with registered output and skid stage.
// Depends on pesp_pkg.
//
// channel  | direction | handshake         | payload
// in       | input     | in_valid/in_stall | in_stream_byte
// out      | output    | out_valid/out_stall | result fields
// cfg      | input     | cfg_we            | cfg_index, cfg_data
//
// One byte per cycle while in_stall is low; the state update is a single registered pass.
// An accepted byte's result is registered in the output register, or in the skid register while out_stall holds it.
// A skid register holds one result while out_stall is high; in_stall rises only
// when both the output and skid registers are full.
// Reset is synchronous, active low.
`default_nettype none
module pes_packet_header_parser_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_stream_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       out_result_kind,
  output logic [7:0]       out_payload_byte,
  output logic             out_last_of_packet,
  output logic [7:0]       out_packet_stream_id,
  output logic             out_pts_present,
  output logic [32:0]      out_pts_value,
  output logic             out_dts_present,
  output logic [32:0]      out_dts_value,
  output logic [1:0]       out_scrambling_mode,
  output logic             out_alignment_flag,
  output logic [15:0]      out_payload_count,
  output logic [1:0]       out_error_code,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [7:0]  cfg_data
);
  import pesp_pkg::*;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  pbyte;
    logic        last;
    logic [7:0]  id;
    logic        pts_p;
    logic [32:0] pts;
    logic        dts_p;
    logic [32:0] dts;
    logic [1:0]  scr;
    logic        align;
    logic [15:0] count;
    logic [1:0]  err;
  } res_t;

  logic [7:0]  wanted_r;
  logic        mpeg2_r;
  phase_t      phase_r, phase_nxt;
  logic [23:0] shift_r, shift_nxt;
  logic [15:0] left_r, left_nxt;
  logic [7:0]  hleft_r, hleft_nxt;
  logic [3:0]  fidx_r, fidx_nxt;
  logic        fl_pts_r, fl_pts_nxt, fl_dts_r, fl_dts_nxt;
  logic        fl_align_r, fl_align_nxt, fl_m2_r, fl_m2_nxt;
  logic [1:0]  fl_scr_r, fl_scr_nxt;
  logic [32:0] pts_r, pts_nxt, dts_r, dts_nxt;
  logic [7:0]  id_r, id_nxt;

  res_t        res_nxt, out_r, skid_r;
  logic        emit_nxt;
  logic        out_v_r, skid_v_r;
  logic        acc;

  assign in_stall = skid_v_r;
  assign acc = in_valid && !skid_v_r;

  logic [7:0]  b;
  logic [15:0] left_dec;
  go_t         r;
  logic        hdr;
  logic        ts_en;
  go_t         ts_r;
  logic        lead_en;
  logic [3:0]  need;
  assign b = in_stream_byte;

  always_comb begin
    logic        second;
    logic [3:0]  pos;
    logic [32:0] a;
    logic [3:0]  lead;
    logic [4:0]  idx;
    phase_nxt = phase_r; shift_nxt = shift_r; left_nxt = left_r; hleft_nxt = hleft_r;
    fidx_nxt = fidx_r; fl_pts_nxt = fl_pts_r; fl_dts_nxt = fl_dts_r;
    fl_align_nxt = fl_align_r; fl_m2_nxt = fl_m2_r; fl_scr_nxt = fl_scr_r;
    pts_nxt = pts_r; dts_nxt = dts_r; id_nxt = id_r;
    res_nxt = '0; emit_nxt = 1'b0;
    left_dec = (left_r != 16'd0) ? left_r - 16'd1 : 16'd0;
    r = GO_ON; hdr = 1'b0; ts_en = 1'b0; ts_r = GO_ON; lead_en = 1'b0;
    need = 4'd0;
    second = 1'b0; pos = 4'd0; a = '0; lead = 4'd0; idx = 5'd0;

    unique case (phase_r)
      PH_PREFIX: begin
        shift_nxt = {shift_r[15:0], b};
        if ((fidx_r < 4'd2) ? (b != 8'd0) : (b != 8'd1)) begin
          phase_nxt = PH_HUNT; fidx_nxt = 4'd0;
          emit_nxt = 1'b1; res_nxt.kind = KIND_ERROR; res_nxt.last = 1'b1;
          res_nxt.err = ERR_PREFIX;
        end else if (fidx_r >= 4'd2) begin
          phase_nxt = PH_ID; fidx_nxt = 4'd0;
        end else begin
          fidx_nxt = fidx_r + 4'd1;
        end
      end
      PH_HUNT: begin
        shift_nxt = {shift_r[15:0], b};
        if ({shift_r[15:0], b} == 24'h000001) phase_nxt = PH_ID;
      end
      PH_ID: begin
        id_nxt = b; phase_nxt = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        left_nxt = {b, 8'd0}; phase_nxt = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        left_nxt = {left_r[15:8], b};
        if (id_r != wanted_r) begin
          if ({left_r[15:8], b} != 16'd0) phase_nxt = PH_SKIP;
          else begin
            phase_nxt = PH_PREFIX; shift_nxt = '0; fidx_nxt = 4'd0;
          end
        end else if ({left_r[15:8], b} == 16'd0) begin
          phase_nxt = PH_PREFIX; shift_nxt = '0; fidx_nxt = 4'd0;
          emit_nxt = 1'b1; res_nxt.kind = KIND_ERROR; res_nxt.last = 1'b1;
          res_nxt.id = id_r; res_nxt.err = ERR_SHORT;
        end else begin
          fl_m2_nxt = mpeg2_r; fl_pts_nxt = 1'b0; fl_dts_nxt = 1'b0;
          fl_align_nxt = 1'b0; fl_scr_nxt = 2'd0;
          pts_nxt = '0; dts_nxt = '0; hleft_nxt = 8'd0; fidx_nxt = 4'd0;
          phase_nxt = mpeg2_r ? PH_M2_B0 : PH_M1_STUFF;
        end
      end
      PH_PAYLOAD: begin
        left_nxt = left_dec;
        emit_nxt = 1'b1; res_nxt.kind = KIND_PAYLOAD; res_nxt.pbyte = b;
        res_nxt.last = (left_dec == 16'd0); res_nxt.id = id_r;
        if (left_dec == 16'd0) begin
          phase_nxt = PH_PREFIX; shift_nxt = '0; fidx_nxt = 4'd0;
        end
      end
      PH_SKIP: begin
        left_nxt = left_dec;
        if (left_dec == 16'd0) begin
          phase_nxt = PH_PREFIX; shift_nxt = '0; fidx_nxt = 4'd0;
        end
      end
      PH_M1_STUFF, PH_M1_STD2, PH_M1_LEAD, PH_M2_B0, PH_M2_B1, PH_M2_B2,
      PH_TS, PH_M2_SKIP: begin
        hdr = 1'b1;
        left_nxt = left_dec;
      end
      default: begin
        phase_nxt = PH_PREFIX; shift_nxt = '0; fidx_nxt = 4'd0;
      end
    endcase

    if (hdr) begin
      unique case (phase_r)
        PH_M1_STUFF: begin
          if (b == 8'hFF) r = GO_ON;
          else if (b[7:6] == 2'b01) begin
            phase_nxt = PH_M1_STD2; r = GO_ON;
          end else lead_en = 1'b1;
        end
        PH_M1_STD2: begin
          phase_nxt = PH_M1_LEAD; r = GO_ON;
        end
        PH_M1_LEAD: lead_en = 1'b1;
        PH_M2_B0: begin
          if (b[7:6] != 2'b10) r = GO_BAD;
          else begin
            fl_scr_nxt = b[5:4];
            if (b[2]) fl_align_nxt = 1'b1;
            phase_nxt = PH_M2_B1;
          end
        end
        PH_M2_B1: begin
          if (b[7:6] == 2'b01) r = GO_BAD;
          else begin
            if (b[7]) fl_pts_nxt = 1'b1;
            if (b[7:6] == 2'b11) fl_dts_nxt = 1'b1;
            phase_nxt = PH_M2_B2;
          end
        end
        PH_M2_B2: begin
          hleft_nxt = b;
          need = fl_dts_r ? 4'd10 : (fl_pts_r ? 4'd5 : 4'd0);
          if (b < {4'd0, need}) r = GO_SHORT;
          else if (need == 4'd0) begin
            if (b == 8'd0) r = GO_DONE;
            else phase_nxt = PH_M2_SKIP;
          end else begin
            fidx_nxt = 4'd0; phase_nxt = PH_TS;
          end
        end
        PH_TS: ts_en = 1'b1;
        default: begin
          hleft_nxt = (hleft_r != 8'd0) ? hleft_r - 8'd1 : 8'd0;
          r = (hleft_nxt == 8'd0) ? GO_DONE : GO_ON;
        end
      endcase

      if (lead_en) begin
        if (b[7:4] == 4'h2 || b[7:4] == 4'h3) begin
          fl_pts_nxt = 1'b1;
          if (b[4]) fl_dts_nxt = 1'b1;
          fidx_nxt = 4'd0; phase_nxt = PH_TS; ts_en = 1'b1;
        end else if (b == 8'h0F) r = GO_DONE;
        else r = GO_BAD;
      end

      if (ts_en) begin
        idx = lead_en ? 5'd0 : {1'b0, fidx_r};
        second = idx >= 5'd5;
        pos = second ? idx[3:0] - 4'd5 : idx[3:0];
        a = second ? dts_r : (lead_en ? 33'd0 : pts_r);
        lead = second ? 4'h1 : (fl_dts_nxt ? 4'h3 : 4'h2);
        ts_r = GO_ON;
        case (pos)
          4'd0: begin
            if (b[7:4] != lead || !b[0]) ts_r = GO_BAD;
            else a = {b[3:1], 30'd0};
          end
          4'd1: a = a | {3'd0, b, 22'd0};
          4'd2: begin
            if (!b[0]) ts_r = GO_BAD;
            else a = a | {11'd0, b[7:1], 15'd0};
          end
          4'd3: a = a | {18'd0, b, 7'd0};
          default: begin
            if (!b[0]) ts_r = GO_BAD;
            else a = a | {26'd0, b[7:1]};
          end
        endcase
        if (ts_r != GO_BAD) begin
          if (second) dts_nxt = a; else pts_nxt = a;
          idx = idx + 5'd1;
          fidx_nxt = idx[3:0];
          if (idx == 5'd10 || (idx == 5'd5 && !fl_dts_nxt)) ts_r = GO_DONE;
        end
        r = ts_r;
        if (!lead_en && fl_m2_r) begin
          hleft_nxt = (hleft_r != 8'd0) ? hleft_r - 8'd1 : 8'd0;
          if (ts_r == GO_DONE && hleft_nxt != 8'd0) begin
            phase_nxt = PH_M2_SKIP; r = GO_ON;
          end
        end
      end

      if (r == GO_DONE) begin
        emit_nxt = 1'b1; res_nxt.kind = KIND_HEADER;
        res_nxt.last = (left_dec == 16'd0); res_nxt.id = id_r;
        res_nxt.pts_p = fl_pts_nxt; res_nxt.pts = fl_pts_nxt ? pts_nxt : '0;
        res_nxt.dts_p = fl_dts_nxt; res_nxt.dts = fl_dts_nxt ? dts_nxt : '0;
        res_nxt.scr = fl_scr_nxt; res_nxt.align = fl_align_nxt;
        res_nxt.count = left_dec;
        if (left_dec == 16'd0) begin
          phase_nxt = PH_PREFIX; shift_nxt = '0; fidx_nxt = 4'd0;
        end else phase_nxt = PH_PAYLOAD;
      end else if (!(r == GO_ON && left_dec != 16'd0)) begin
        emit_nxt = 1'b1; res_nxt.kind = KIND_ERROR; res_nxt.last = 1'b1;
        res_nxt.id = id_r; res_nxt.err = (r == GO_BAD) ? ERR_MARKER : ERR_SHORT;
        if (left_dec != 16'd0) phase_nxt = PH_SKIP;
        else begin
          phase_nxt = PH_PREFIX; shift_nxt = '0; fidx_nxt = 4'd0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wanted_r <= 8'd224; mpeg2_r <= 1'b1;
      phase_r <= PH_PREFIX; shift_r <= '0; left_r <= '0; hleft_r <= '0;
      fidx_r <= '0; fl_pts_r <= 1'b0; fl_dts_r <= 1'b0; fl_align_r <= 1'b0;
      fl_m2_r <= 1'b0; fl_scr_r <= '0; pts_r <= '0; dts_r <= '0; id_r <= '0;
      out_v_r <= 1'b0; skid_v_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_WANTED_ID: wanted_r <= cfg_data;
          CFG_MPEG2:     mpeg2_r <= cfg_data[0];
          default: ;
        endcase
      end
      if (acc) begin
        phase_r <= phase_nxt; shift_r <= shift_nxt; left_r <= left_nxt;
        hleft_r <= hleft_nxt; fidx_r <= fidx_nxt; fl_pts_r <= fl_pts_nxt;
        fl_dts_r <= fl_dts_nxt; fl_align_r <= fl_align_nxt; fl_m2_r <= fl_m2_nxt;
        fl_scr_r <= fl_scr_nxt; pts_r <= pts_nxt; dts_r <= dts_nxt; id_r <= id_nxt;
      end
      if (!out_v_r || !out_stall) begin
        if (skid_v_r) begin
          out_v_r <= 1'b1; out_r <= skid_r; skid_v_r <= 1'b0;
        end else begin
          out_v_r <= acc && emit_nxt; out_r <= res_nxt;
        end
      end else if (acc && emit_nxt) begin
        skid_v_r <= 1'b1; skid_r <= res_nxt;
      end
    end
  end

  assign out_valid            = out_v_r;
  assign out_result_kind      = out_r.kind;
  assign out_payload_byte     = out_r.pbyte;
  assign out_last_of_packet   = out_r.last;
  assign out_packet_stream_id = out_r.id;
  assign out_pts_present      = out_r.pts_p;
  assign out_pts_value        = out_r.pts;
  assign out_dts_present      = out_r.dts_p;
  assign out_dts_value        = out_r.dts;
  assign out_scrambling_mode  = out_r.scr;
  assign out_alignment_flag   = out_r.align;
  assign out_payload_count    = out_r.count;
  assign out_error_code       = out_r.err;
endmodule
`default_nettype wire
